FILE: rtl/ibl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_pkg
// Shared types, constants and a helper function for the inverted 5x5 blur.
// ----------------------------------------------------------------------------
package ibl_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_W_W    = 12;
    localparam int CFG_H_W    = 16;
    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int LINE_ROWS  = 4;
    localparam int WIN        = 5;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);

    // Ceiling divide by 35: (sum + 34) * 29960 >> 20 is exact for sums below 43680
    localparam int DIV_ROUND  = 34;
    localparam int DIV_MUL    = 29960;
    localparam int DIV_SHIFT  = 20;
    localparam int ROWSUM_W   = 12;
    localparam int TOTAL_W    = 14;
    localparam int MUL_W      = 15;
    localparam int PROD_W     = TOTAL_W + MUL_W;

    // Configuration register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        t_win             win;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_col;
        logic             last_row;
    } t_job;

    // Tap weight for window slot (i, j) of a centre offset by (dr, dc); 0 when unused
    function automatic logic [1:0] tap_wt(input int i, input int j,
                                          input logic [1:0] dr, input logic [1:0] dc);
        int dy;
        int dx;
        int m;
        dy = i - 2 - int'(dr);
        dx = j - 2 - int'(dc);
        if (dy < 0) dy = -dy;
        if (dx < 0) dx = -dx;
        m = (dy > dx) ? dy : dx;
        if (i < int'(dr) || j < int'(dc) || m > 2) begin
            return 2'd0;
        end
        return 2'(3 - m);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ibl_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_pix_if
// Pixel input channel: valid/ready handshake with one RGB pixel.
// ----------------------------------------------------------------------------
interface ibl_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;

    modport source(output valid, output blue_in, output green_in, output red_in,
                   input ready);
    modport sink(input valid, input blue_in, input green_in, input red_in,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/ibl_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_res_if
// Result channel: valid/ready handshake with one blurred, inverted pixel.
// ----------------------------------------------------------------------------
interface ibl_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  blue_out;
    logic [7:0]  green_out;
    logic [7:0]  red_out;
    logic [10:0] out_col;
    logic [15:0] out_row;
    logic        last_of_run;
    logic        frame_done;

    modport source(output valid, output blue_out, output green_out, output red_out,
                   output out_col, output out_row, output last_of_run,
                   output frame_done, input ready);
    modport sink(input valid, input blue_out, input green_out, input red_out,
                 input out_col, input out_row, input last_of_run,
                 input frame_done, output ready);
endinterface
`default_nettype wire

FILE: rtl/ibl_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_ram
// Generic single-port RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module ibl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read old contents, then write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ibl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_front
// Accept pixels, keep the line stores and the 5x5 window, queue centre jobs.
// ----------------------------------------------------------------------------
module ibl_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [ibl_pkg::CFG_W_W-1:0] i_width,
    input  wire logic [ibl_pkg::CFG_H_W-1:0] i_height,
    ibl_pix_if.sink                       i_pix,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output ibl_pkg::t_job                 o_job
);
    import ibl_pkg::*;

    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [CFG_W_W-1:0] w_eff;
    logic [CFG_H_W-1:0] h_eff;
    logic               accept;
    logic               last_col;
    logic               last_row;
    logic [PIX_W-1:0]   rd_data [LINE_ROWS];

    logic               r_s1_valid;
    t_pix               r_s1_pix;
    logic [COL_W-1:0]   r_s1_col;
    logic [ROW_W-1:0]   r_s1_row;
    logic               r_s1_last_col;
    logic               r_s1_last_row;
    t_win               r_win;
    t_win               n_win;
    logic               s1_emit;
    logic               s1_adv;

    // Clamp frame size
    always_comb begin
        if (i_width < CFG_W_W'(3)) begin
            w_eff = CFG_W_W'(3);
        end else if (i_width > CFG_W_W'(MAX_WIDTH)) begin
            w_eff = CFG_W_W'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        h_eff = (i_height < CFG_H_W'(3)) ? CFG_H_W'(3) : i_height;
    end

    assign last_col = {1'b0, r_col} >= (w_eff - CFG_W_W'(1));
    assign last_row = r_row >= (h_eff - CFG_H_W'(1));

    assign s1_emit     = r_s1_valid && (r_s1_row >= ROW_W'(2)) && (r_s1_col >= COL_W'(2));
    assign s1_adv      = r_s1_valid && (!s1_emit || !i_q_full);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;

    // Line stores, one per row slot
    for (genvar k = 0; k < LINE_ROWS; k++) begin : g_line
        ibl_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && (r_row[1:0] == 2'(k))),
            .i_re    (accept),
            .i_addr  (r_col[ADDR_W-1:0]),
            .i_wdata ({i_pix.red_in, i_pix.green_in, i_pix.blue_in}),
            .o_rdata (rd_data[k])
        );
    end

    // Advance raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Hold the accepted pixel while the line stores answer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix      <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
            r_s1_col      <= r_col;
            r_s1_row      <= r_row;
            r_s1_last_col <= last_col;
            r_s1_last_row <= last_row;
        end
    end

    // Shift the window left and load the new column
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) begin
                n_win[i][j] = r_win[i][j+1];
            end
        end
        for (int i = 0; i < LINE_ROWS; i++) begin
            n_win[i][WIN-1] = rd_data[2'(r_s1_row[1:0] + 2'(i))];
        end
        n_win[WIN-1][WIN-1] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_win <= n_win;
        end
    end

    assign o_push         = s1_adv && s1_emit;
    assign o_job.win      = n_win;
    assign o_job.col      = r_s1_col;
    assign o_job.row      = r_s1_row;
    assign o_job.last_col = r_s1_last_col;
    assign o_job.last_row = r_s1_last_row;
endmodule
`default_nettype wire

FILE: rtl/ibl_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_queue
// Two-entry job queue between the window front and the arithmetic back.
// ----------------------------------------------------------------------------
module ibl_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ibl_pkg::t_job i_job,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output ibl_pkg::t_job      o_job
);
    import ibl_pkg::*;

    t_job       r_ent [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_ent[r_rp];

    // Store on push
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_job;
        end
    end

    // Move pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ibl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibl_back
// Walk job centres, compute the inverted blur one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ibl_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire ibl_pkg::t_job i_job,
    output logic               o_pop,
    ibl_res_if.source          o_res
);
    import ibl_pkg::*;

    logic             en;
    logic             issue;
    logic [1:0]       r_dr;
    logic [1:0]       r_dc;
    logic [1:0]       ndr;
    logic [1:0]       ndc;
    logic             last_dr;
    logic             last_dc;
    logic [WIN-1:0]   row_ok;
    logic [WIN-1:0]   col_ok;
    logic [ROWSUM_W-1:0] n_a_sum [3][WIN];

    logic                r_a_valid;
    logic [ROWSUM_W-1:0] r_a_sum [3][WIN];
    logic [COL_W-1:0]    r_a_col;
    logic [ROW_W-1:0]    r_a_row;
    logic                r_a_last;
    logic                r_a_done;

    logic                r_b_valid;
    logic [TOTAL_W-1:0]  r_b_tot [3];
    logic [COL_W-1:0]    r_b_col;
    logic [ROW_W-1:0]    r_b_row;
    logic                r_b_last;
    logic                r_b_done;

    logic                r_c_valid;
    logic [PROD_W-1:0]   r_c_prod [3];
    logic [COL_W-1:0]    r_c_col;
    logic [ROW_W-1:0]    r_c_row;
    logic                r_c_last;
    logic                r_c_done;

    logic                r_o_valid;
    logic [CH_W-1:0]     r_o_ch [3];
    logic [COL_W-1:0]    r_o_col;
    logic [ROW_W-1:0]    r_o_row;
    logic                r_o_last;
    logic                r_o_done;

    // Whole pipe moves when the output register is free
    assign en      = !r_o_valid || o_res.ready;
    assign ndr     = i_job.last_row ? 2'd3 : 2'd1;
    assign ndc     = i_job.last_col ? 2'd3 : 2'd1;
    assign last_dr = r_dr == ndr - 2'd1;
    assign last_dc = r_dc == ndc - 2'd1;
    assign issue   = en && i_q_valid;
    assign o_pop   = issue && last_dr && last_dc;

    // Step through the centres of the head job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dr <= 2'd0;
            r_dc <= 2'd0;
        end else if (issue) begin
            if (last_dc) begin
                r_dc <= 2'd0;
                r_dr <= last_dr ? 2'd0 : r_dr + 2'd1;
            end else begin
                r_dc <= r_dc + 2'd1;
            end
        end
    end

    // Mark window slots that lie inside the frame
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            row_ok[i] = ({1'b0, i_job.row} + (ROW_W+1)'(i)) >= (ROW_W+1)'(4);
            col_ok[i] = ({1'b0, i_job.col} + (COL_W+1)'(i)) >= (COL_W+1)'(4);
        end
    end

    // Weighted row sums per channel
    always_comb begin
        logic [1:0]      w;
        logic [CH_W-1:0] p;
        logic [9:0]      t;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < WIN; i++) begin
                n_a_sum[ch][i] = '0;
                for (int j = 0; j < WIN; j++) begin
                    w = (row_ok[i] && col_ok[j]) ? tap_wt(i, j, r_dr, r_dc) : 2'd0;
                    p = i_job.win[i][j][ch*CH_W +: CH_W];
                    unique case (w)
                        2'd1:    t = {2'b00, p};
                        2'd2:    t = {1'b0, p, 1'b0};
                        2'd3:    t = {2'b00, p} + {1'b0, p, 1'b0};
                        default: t = '0;
                    endcase
                    n_a_sum[ch][i] = n_a_sum[ch][i] + ROWSUM_W'(t);
                end
            end
        end
    end

    // Pipeline: row sums, total, reciprocal product, inverted output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= issue;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_o_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sum  <= n_a_sum;
            r_a_col  <= i_job.col - COL_W'(2) + COL_W'(r_dc);
            r_a_row  <= i_job.row - ROW_W'(2) + ROW_W'(r_dr);
            r_a_last <= last_dr && last_dc;
            r_a_done <= last_dr && last_dc && i_job.last_col && i_job.last_row;

            for (int ch = 0; ch < 3; ch++) begin
                r_b_tot[ch] <= TOTAL_W'(r_a_sum[ch][0]) + TOTAL_W'(r_a_sum[ch][1])
                             + TOTAL_W'(r_a_sum[ch][2]) + TOTAL_W'(r_a_sum[ch][3])
                             + TOTAL_W'(r_a_sum[ch][4]) + TOTAL_W'(DIV_ROUND);
                r_c_prod[ch] <= PROD_W'(r_b_tot[ch]) * PROD_W'(DIV_MUL);
                r_o_ch[ch]   <= CH_W'(255) - r_c_prod[ch][DIV_SHIFT +: CH_W];
            end
            r_b_col  <= r_a_col;
            r_b_row  <= r_a_row;
            r_b_last <= r_a_last;
            r_b_done <= r_a_done;
            r_c_col  <= r_b_col;
            r_c_row  <= r_b_row;
            r_c_last <= r_b_last;
            r_c_done <= r_b_done;
            r_o_col  <= r_c_col;
            r_o_row  <= r_c_row;
            r_o_last <= r_c_last;
            r_o_done <= r_c_done;
        end
    end

    assign o_res.valid       = r_o_valid;
    assign o_res.blue_out    = r_o_ch[0];
    assign o_res.green_out   = r_o_ch[1];
    assign o_res.red_out     = r_o_ch[2];
    assign o_res.out_col     = r_o_col;
    assign o_res.out_row     = r_o_row;
    assign o_res.last_of_run = r_o_last;
    assign o_res.frame_done  = r_o_done;

    // End of frame only on the final centre of a job
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (!r_o_done || r_o_last))
        else $error("frame_done without last_of_run");

    // Centre counters stay within the job's centre grid
    a_seq_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_dr < ndr && r_dc < ndc))
        else $error("centre counter out of range");

    // A stalled output holds its data
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_res.ready) |=> (r_o_valid && $stable(r_o_col) && $stable(r_o_row)))
        else $error("stalled result changed");

    // Counters rewind when a job is popped
    a_pop_rewind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_dr == 2'd0 && r_dc == 2'd0))
        else $error("counters not rewound after pop");
endmodule
`default_nettype wire

FILE: rtl/inverted_blur5x5_rgb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inverted_blur5x5_rgb
// Inverted 5x5 weighted blur of a raster RGB stream with APB frame setup.
// ----------------------------------------------------------------------------
//  Port      | Dir | Transfer
//  i_pix     | in  | one RGB pixel, raster order, valid/ready
//  o_res     | out | one inverted blurred centre with position and flags
//  APB       | in  | writes image_width (0x0), image_height (0x4)
//
//  Takes one pixel per cycle while the queue has room; each queued job yields
//  one result per cycle while results are taken: 3 at a row end, and 3 or 9
//  per pixel on the last row. After its pixel's transfer a result passes the
//  pixel hold, queue, row sums, total, reciprocal product and output registers.
//  Reset is synchronous, active low; line stores need no clearing.
//  A two-job queue lets the pixel side run while results are stalled.
// ----------------------------------------------------------------------------
module inverted_blur5x5_rgb (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    ibl_pix_if.sink          i_pix,
    ibl_res_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ibl_pkg::*;

    logic [CFG_W_W-1:0] r_width;
    logic [CFG_H_W-1:0] r_height;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    t_job               push_job;
    t_job               head_job;

    assign pready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W_W'(640);
            r_height <= CFG_H_W'(480);
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_H_W-1:0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {20'd0, r_width};
            REG_HEIGHT: prdata = {16'd0, r_height};
            default:    prdata = '0;
        endcase
    end

    ibl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_pix    (i_pix),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    ibl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (head_job)
    );

    ibl_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_job     (head_job),
        .o_pop     (pop),
        .o_res     (o_res)
    );
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the inverted 5x5 RGB blur against a cycle-free predictor. Whole
// frames are streamed with random idling on both sides. Frame sizes are set
// over APB between frames, including clamped values; a full-scale width and
// a full-scale height are each cut short by a write in the middle of a frame.
// ----------------------------------------------------------------------------
module testbench;
    import ibl_pkg::*;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [2:0]  ADDR_WIDTH     = 3'd0;
    localparam logic [2:0]  ADDR_HEIGHT    = 3'd4;

    typedef struct packed {
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last_of_run;
        logic             frame_done;
    } t_blur_res;

    // Predicts blurred pixels and matches them against the block's results
    class blur_scoreboard;
        int unsigned cfg_width;
        int unsigned cfg_height;
        logic [PIX_W-1:0] lines[LINE_ROWS][MAX_WIDTH];
        logic [PIX_W-1:0] win[WIN][WIN];
        int unsigned col_ptr;
        int unsigned row_ptr;
        t_blur_res   awaited[$];
        int unsigned mismatches;
        int unsigned results_seen;

        function new();
            cfg_width  = 640;
            cfg_height = 480;
            col_ptr    = 0;
            row_ptr    = 0;
            mismatches = 0;
            results_seen = 0;
            foreach (lines[i, j]) lines[i][j] = '0;
            foreach (win[i, j]) win[i][j] = '0;
        endfunction

        function void write_reg(logic [2:0] addr, logic [31:0] value);
            if (addr == ADDR_WIDTH) cfg_width = value[CFG_W_W-1:0];
            else cfg_height = value[CFG_H_W-1:0];
        endfunction

        function logic [7:0] invert(int unsigned sum);
            return 8'(255 - (sum + 34) / 35);
        endfunction

        // Form one centre lying dr rows and dc columns past the window middle
        function t_blur_res centre(int unsigned r, int unsigned c, int dr, int dc);
            t_blur_res res;
            int unsigned sb, sg, sr, wt;
            int dy, dx, m;
            sb = 0;
            sg = 0;
            sr = 0;
            for (int i = dr; i < WIN; i++) begin
                if (r + i < 4) continue;
                for (int j = dc; j < WIN; j++) begin
                    if (c + j < 4) continue;
                    dy = i - 2 - dr;
                    dx = j - 2 - dc;
                    if (dy < 0) dy = -dy;
                    if (dx < 0) dx = -dx;
                    m  = (dy > dx) ? dy : dx;
                    wt = 3 - m;
                    sb += wt * win[i][j][7:0];
                    sg += wt * win[i][j][15:8];
                    sr += wt * win[i][j][23:16];
                end
            end
            res.blue        = invert(sb);
            res.green       = invert(sg);
            res.red         = invert(sr);
            res.col         = COL_W'(c - 2 + dc);
            res.row         = ROW_W'(r - 2 + dr);
            res.last_of_run = 1'b0;
            res.frame_done  = 1'b0;
            return res;
        endfunction

        // Advance the window for one accepted pixel and queue its results
        function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r_in);
            int unsigned w, h, r, c;
            logic [PIX_W-1:0] pix;
            bit lastc, lastr;
            int ndr, ndc;
            w = cfg_width;
            h = cfg_height;
            r = row_ptr;
            c = col_ptr;
            if (w < 3) w = 3;
            if (w > MAX_WIDTH) w = MAX_WIDTH;
            if (h < 3) h = 3;
            if (c >= MAX_WIDTH) c = MAX_WIDTH - 1;
            pix = {r_in, g, b};
            for (int i = 0; i < WIN; i++)
                for (int j = 0; j < WIN - 1; j++)
                    win[i][j] = win[i][j+1];
            for (int i = 0; i < LINE_ROWS; i++)
                win[i][WIN-1] = lines[(r + i) % LINE_ROWS][c];
            win[WIN-1][WIN-1] = pix;
            lines[r % LINE_ROWS][c] = pix;
            lastc = (c >= w - 1);
            lastr = (r >= h - 1);
            if (r >= 2 && c >= 2) begin
                ndr = lastr ? 3 : 1;
                ndc = lastc ? 3 : 1;
                for (int dr = 0; dr < ndr; dr++)
                    for (int dc = 0; dc < ndc; dc++)
                        awaited.push_back(centre(r, c, dr, dc));
                awaited[awaited.size()-1].last_of_run = 1'b1;
                if (lastc && lastr) awaited[awaited.size()-1].frame_done = 1'b1;
            end
            if (lastc) begin
                col_ptr = 0;
                row_ptr = lastr ? 0 : r + 1;
            end else begin
                col_ptr = c + 1;
            end
        endfunction

        function void check_result(t_blur_res got);
            t_blur_res exp_res;
            results_seen++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result at row %0d col %0d", got.row, got.col);
                return;
            end
            exp_res = awaited.pop_front();
            if (got != exp_res) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"mismatch: exp rgb %0d/%0d/%0d r%0d c%0d l%0b f%0b,",
                              " got rgb %0d/%0d/%0d r%0d c%0d l%0b f%0b"},
                             exp_res.red, exp_res.green, exp_res.blue, exp_res.row,
                             exp_res.col, exp_res.last_of_run, exp_res.frame_done,
                             got.red, got.green, got.blue, got.row, got.col,
                             got.last_of_run, got.frame_done);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ibl_pix_if pix_ch();
    ibl_res_if res_ch();

    blur_scoreboard blur_sb;
    int unsigned pixels_sent;
    int unsigned frames_sent;
    int unsigned snd_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned quiet_cycles;
    bit          apb_fire;

    inverted_blur5x5_rgb dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        res_ch.ready = ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        t_blur_res got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.blue        = res_ch.blue_out;
            got.green       = res_ch.green_out;
            got.red         = res_ch.red_out;
            got.col         = res_ch.out_col;
            got.row         = res_ch.out_row;
            got.last_of_run = res_ch.last_of_run;
            got.frame_done  = res_ch.frame_done;
            blur_sb.check_result(got);
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || apb_fire || (pix_ch.valid && pix_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one pixel and hold it until the transfer
    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            pix_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid    = 1'b1;
        pix_ch.blue_in  = b;
        pix_ch.green_in = g;
        pix_ch.red_in   = r;
        do @(posedge i_clk); while (!pix_ch.ready);
        blur_sb.note_pixel(b, g, r);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    // Offer a run of random pixels
    task automatic send_random(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_pixel(pick_channel(), pick_channel(), pick_channel());
    endtask

    // Hold off until every result is out and the pipeline has drained
    task automatic wait_drained();
        pix_ch.valid = 1'b0;
        while (blur_sb.awaited.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        apb_fire = 1'b1;
        blur_sb.write_reg(addr, value);
        @(negedge i_clk);
        apb_fire = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
    endtask

    // Set the frame size, then stream one whole frame; fill < 0 means random
    task automatic send_frame(int unsigned w_reg, int unsigned h_reg, int fill);
        int unsigned w_eff, h_eff;
        wait_drained();
        apb_write(ADDR_WIDTH, w_reg);
        apb_write(ADDR_HEIGHT, h_reg);
        w_eff = blur_sb.cfg_width < 3 ? 3 :
                (blur_sb.cfg_width > MAX_WIDTH ? MAX_WIDTH : blur_sb.cfg_width);
        h_eff = blur_sb.cfg_height < 3 ? 3 : blur_sb.cfg_height;
        for (int unsigned n = 0; n < w_eff * h_eff; n++) begin
            if (fill < 0) send_pixel(pick_channel(), pick_channel(), pick_channel());
            else send_pixel(8'(fill), 8'(fill), 8'(fill));
        end
        frames_sent++;
    endtask

    initial begin
        int unsigned w_reg, h_reg;
        blur_sb         = new();
        pixels_sent     = 0;
        frames_sent     = 0;
        quiet_cycles    = 0;
        apb_fire        = 1'b0;
        snd_idle_pct    = 9;
        rcv_idle_pct    = 60;
        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.blue_in  = '0;
        pix_ch.green_in = '0;
        pix_ch.red_in   = '0;
        res_ch.ready    = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: smallest frame, saturated white then black
        send_frame(3, 3, 255);
        send_frame(3, 3, 0);

        // Random small frames, clamped sizes now and then
        while (pixels_sent < 340) begin
            if (pixels_sent > 230) begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (pixels_sent > 120) begin
                snd_idle_pct = 60;
                rcv_idle_pct = 9;
            end
            w_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h_reg = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            send_frame(w_reg, h_reg, -1);
        end

        // Full-scale width register, then narrow the line mid-row
        wait_drained();
        apb_write(ADDR_WIDTH, 12'hFFF);
        apb_write(ADDR_HEIGHT, 3);
        send_random(5);
        wait_drained();
        apb_write(ADDR_WIDTH, 8);
        send_random(19);
        frames_sent++;

        // Full-scale height, then cut the frame short after three rows
        wait_drained();
        apb_write(ADDR_WIDTH, 3);
        apb_write(ADDR_HEIGHT, 16'hFFFF);
        send_random(9);
        wait_drained();
        apb_write(ADDR_HEIGHT, 4);
        send_random(3);
        frames_sent++;

        wait_drained();
        $display("streamed %0d pixels in %0d frames, %0d results checked",
                 pixels_sent, frames_sent, blur_sb.results_seen);
        $display("sizes from clamped 3x3 up to full-scale registers cut short mid-frame");
        if (blur_sb.mismatches == 0 && blur_sb.awaited.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
